FILE: design/rhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL converter package
// Shared constants, command codes and the forward lane bundle.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Default number of fraction bits for hue, saturation and lightness.
  localparam int FRAC_BITS_DEF = 16;

  // Forward dividers work on small integers: numerator and divisor fit 11 bits.
  localparam int NW = 11;
  localparam int RW = NW + 1;

  // Divider lanes.
  localparam int LANES      = 3;
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;
  localparam int LANE_LIGHT = 2;

  // Number of register stages in the divider and in the reverse path.
  localparam int CORE_STAGES = 4;

  // Direction codes.
  localparam logic CMD_RGB2HSL = 1'b0;
  localparam logic CMD_HSL2RGB = 1'b1;

  // Lightness divides the channel sum by twice full scale.
  localparam logic [NW-1:0] LIGHT_DIV = 11'd510;
  localparam logic [8:0]    HALF_SUM  = 9'd255;
  localparam logic [8:0]    FULL_SUM  = 9'd510;

  // Hue sextants.
  localparam logic [2:0] SEXT_0 = 3'd0;
  localparam logic [2:0] SEXT_1 = 3'd1;
  localparam logic [2:0] SEXT_2 = 3'd2;
  localparam logic [2:0] SEXT_3 = 3'd3;
  localparam logic [2:0] SEXT_4 = 3'd4;

  // Forward work handed from the front stage to the divider.
  typedef struct packed {
    logic                     cmd;
    logic                     grey;
    logic [LANES-1:0][NW-1:0] num;
    logic [LANES-1:0][NW-1:0] den;
  } fwd_t;

endpackage

FILE: design/rhc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL input channel
// Valid/ready channel that carries one conversion request per item.
// ----------------------------------------------------------------------------
interface rhc_in_if #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [7:0]           red_in;
  logic [7:0]           green_in;
  logic [7:0]           blue_in;
  logic [FRAC_BITS-1:0] hue_in;
  logic [FRAC_BITS:0]   sat_in;
  logic [FRAC_BITS:0]   light_in;

  modport source (
    output valid, cmd, red_in, green_in, blue_in, hue_in, sat_in, light_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, red_in, green_in, blue_in, hue_in, sat_in, light_in,
    output ready
  );
endinterface

FILE: design/rhc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL output channel
// Valid/ready channel that carries one conversion result per item.
// ----------------------------------------------------------------------------
interface rhc_out_if #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [7:0]           red_out;
  logic [7:0]           green_out;
  logic [7:0]           blue_out;
  logic [FRAC_BITS-1:0] hue_out;
  logic [FRAC_BITS:0]   sat_out;
  logic [FRAC_BITS:0]   light_out;

  modport source (
    output valid, red_out, green_out, blue_out, hue_out, sat_out, light_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, hue_out, sat_out, light_out,
    output ready
  );
endinterface

FILE: design/rhc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL front stage
// Finds max/min and the divider operands, clamps HSL and forms l*(1+s) or l*s.
// ----------------------------------------------------------------------------
module rhc_front #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 cmd,
  input  logic [7:0]           red_in,
  input  logic [7:0]           green_in,
  input  logic [7:0]           blue_in,
  input  logic [FRAC_BITS-1:0] hue_in,
  input  logic [FRAC_BITS:0]   sat_in,
  input  logic [FRAC_BITS:0]   light_in,
  output rhc_pkg::fwd_t        fwd,
  output logic                 cmd_q,
  output logic [FRAC_BITS-1:0] hue_q,
  output logic [FRAC_BITS:0]   sat_q,
  output logic [FRAC_BITS:0]   light_q,
  output logic [2*FRAC_BITS+2:0] prod_q,
  output logic                 half_q
);
  import rhc_pkg::*;

  localparam logic [FRAC_BITS:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

  logic [7:0]            mx, mn, dif;
  logic [8:0]            sum;
  logic [NW-1:0]         d11, d6, hnum;
  fwd_t                  fwd_next;
  logic [FRAC_BITS:0]    s_c, l_c;
  logic                  half;
  logic [FRAC_BITS+1:0]  mop;
  logic [2*FRAC_BITS+2:0] prod;

  // Forward operands: channel extremes and the three numerator/divisor pairs.
  always_comb begin
    mx = red_in;
    if (green_in > mx) mx = green_in;
    if (blue_in > mx) mx = blue_in;
    mn = red_in;
    if (green_in < mn) mn = green_in;
    if (blue_in < mn) mn = blue_in;
    dif = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    d11 = {3'b0, dif};
    d6  = (d11 << 2) + (d11 << 1);
    // Red wins ties, then green.
    if (red_in == mx) begin
      if (green_in >= blue_in) hnum = {3'b0, green_in} - {3'b0, blue_in};
      else hnum = d6 - ({3'b0, blue_in} - {3'b0, green_in});
    end else if (green_in == mx) begin
      hnum = (d11 << 1) + {3'b0, blue_in} - {3'b0, red_in};
    end else begin
      hnum = (d11 << 2) + {3'b0, red_in} - {3'b0, green_in};
    end
    fwd_next.cmd  = cmd;
    fwd_next.grey = (dif == 8'd0);
    fwd_next.num[LANE_HUE]   = hnum;
    fwd_next.den[LANE_HUE]   = d6;
    fwd_next.num[LANE_SAT]   = d11;
    fwd_next.den[LANE_SAT]   = (sum < HALF_SUM) ? {2'b0, sum} : {2'b0, FULL_SUM - sum};
    fwd_next.num[LANE_LIGHT] = {2'b0, sum};
    fwd_next.den[LANE_LIGHT] = LIGHT_DIV;
  end

  // Reverse operands: clamp to one and form the product behind v.
  always_comb begin
    s_c  = (sat_in > ONE) ? ONE : sat_in;
    l_c  = (light_in > ONE) ? ONE : light_in;
    half = (l_c <= HALF);
    mop  = half ? ({1'b0, ONE} + {1'b0, s_c}) : {1'b0, s_c};
    prod = {{(FRAC_BITS+2){1'b0}}, l_c} * {{(FRAC_BITS+1){1'b0}}, mop};
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      fwd     <= fwd_next;
      cmd_q   <= cmd;
      hue_q   <= hue_in;
      sat_q   <= s_c;
      light_q <= l_c;
      prod_q  <= prod;
      half_q  <= half;
    end
  end
endmodule

FILE: design/rhc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL forward divider
// Three-lane restoring divider, x * 2^F / D, spread over four stages.
// ----------------------------------------------------------------------------
module rhc_div #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  rhc_pkg::fwd_t        fwd,
  output logic [FRAC_BITS-1:0] hue,
  output logic [FRAC_BITS:0]   sat,
  output logic [FRAC_BITS:0]   light
);
  import rhc_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int SPS = (QW + CORE_STAGES - 1) / CORE_STAGES;

  logic [LANES-1:0][NW-1:0] rem_r [CORE_STAGES];
  logic [LANES-1:0][QW-1:0] quo_r [CORE_STAGES];
  logic [LANES-1:0][NW-1:0] den_r [CORE_STAGES];
  logic [CORE_STAGES-1:0]   cmd_r, grey_r;

  logic [LANES-1:0][NW-1:0] rem_n [CORE_STAGES];
  logic [LANES-1:0][QW-1:0] quo_n [CORE_STAGES];

  // Stages retire up to SPS quotient bits a lane; the first bit needs no shift.
  always_comb begin
    logic [NW-1:0] r, dv;
    logic [RW-1:0] tr;
    logic [QW-1:0] q;
    for (int st = 0; st < CORE_STAGES; st++) begin
      for (int ln = 0; ln < LANES; ln++) begin
        if (st == 0) begin
          r  = fwd.num[ln];
          dv = fwd.den[ln];
          q  = '0;
        end else begin
          r  = rem_r[st-1][ln];
          dv = den_r[st-1][ln];
          q  = quo_r[st-1][ln];
        end
        for (int j = 0; j < SPS; j++) begin
          if (st * SPS + j < QW) begin
            tr = (st * SPS + j == 0) ? {1'b0, r} : {r, 1'b0};
            if (tr >= {1'b0, dv}) begin
              tr = tr - {1'b0, dv};
              q  = {q[QW-2:0], 1'b1};
            end else begin
              q  = {q[QW-2:0], 1'b0};
            end
            r = tr[NW-1:0];
          end
        end
        rem_n[st][ln] = r;
        quo_n[st][ln] = q;
      end
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int st = 0; st < CORE_STAGES; st++) begin
        rem_r[st] <= rem_n[st];
        quo_r[st] <= quo_n[st];
        if (st == 0) begin
          den_r[st]  <= fwd.den;
          cmd_r[st]  <= fwd.cmd;
          grey_r[st] <= fwd.grey;
        end else begin
          den_r[st]  <= den_r[st-1];
          cmd_r[st]  <= cmd_r[st-1];
          grey_r[st] <= grey_r[st-1];
        end
      end
    end
  end

  // Fields of the other direction read as zero; grey has no hue or saturation.
  always_comb begin
    hue   = '0;
    sat   = '0;
    light = '0;
    if (cmd_r[CORE_STAGES-1] == CMD_RGB2HSL) begin
      light = quo_r[CORE_STAGES-1][LANE_LIGHT];
      if (!grey_r[CORE_STAGES-1]) begin
        hue = quo_r[CORE_STAGES-1][LANE_HUE][FRAC_BITS-1:0];
        sat = quo_r[CORE_STAGES-1][LANE_SAT];
      end
    end
  end
endmodule

FILE: design/rhc_rev.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL reverse path
// Four stages: v and m, the sextant ramp, channel select, byte scaling.
// ----------------------------------------------------------------------------
module rhc_rev #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   cmd,
  input  logic [FRAC_BITS-1:0]   hue,
  input  logic [FRAC_BITS:0]     sat,
  input  logic [FRAC_BITS:0]     light,
  input  logic [2*FRAC_BITS+2:0] prod,
  input  logic                   half,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue
);
  import rhc_pkg::*;

  localparam int F = FRAC_BITS;

  // Stage 1 registers.
  logic           cmd1, vz1;
  logic [F:0]     v1, m1, l1;
  logic [2:0]     sx1;
  logic [F-1:0]   f1;
  // Stage 2 registers.
  logic           cmd2, vz2;
  logic [F:0]     v2, m2, l2, t2;
  logic [2:0]     sx2;
  // Stage 3 registers.
  logic           cmd3;
  logic [F:0]     c3 [3];

  logic [F+1:0]   ph, vs, l2x, mt;
  logic [F:0]     v_n, m_n;
  logic [F+2:0]   h6;
  logic [2*F:0]   tp;
  logic [F:0]     up, down;
  logic [F:0]     c_n [3];
  logic [7:0]     b_n [3];

  // v from the product, then m = 2l - v kept within 0..v, and the sextant split.
  always_comb begin
    ph  = prod[2*F+1:F];
    vs  = {1'b0, light} + {1'b0, sat} - ph;
    v_n = half ? ph[F:0] : vs[F:0];
    l2x = {light, 1'b0};
    mt  = (l2x > {1'b0, v_n}) ? (l2x - {1'b0, v_n}) : '0;
    m_n = (mt > {1'b0, v_n}) ? v_n : mt[F:0];
    h6  = ({3'b0, hue} << 2) + ({3'b0, hue} << 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= cmd;
      vz1  <= (v_n == '0);
      v1   <= v_n;
      m1   <= m_n;
      l1   <= light;
      sx1  <= h6[F+2:F];
      f1   <= h6[F-1:0];
    end
  end

  // Ramp within the sextant.
  assign tp = (v1 - m1) * {1'b0, f1};

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2 <= cmd1;
      vz2  <= vz1;
      v2   <= v1;
      m2   <= m1;
      l2   <= l1;
      t2   <= tp[2*F:F];
      sx2  <= sx1;
    end
  end

  // Channel selection by sextant; a zero v gives lightness on every channel.
  always_comb begin
    up   = m2 + t2;
    down = v2 - t2;
    unique case (sx2)
      SEXT_0:  begin c_n[0] = v2;   c_n[1] = up;   c_n[2] = m2;   end
      SEXT_1:  begin c_n[0] = down; c_n[1] = v2;   c_n[2] = m2;   end
      SEXT_2:  begin c_n[0] = m2;   c_n[1] = v2;   c_n[2] = up;   end
      SEXT_3:  begin c_n[0] = m2;   c_n[1] = down; c_n[2] = v2;   end
      SEXT_4:  begin c_n[0] = up;   c_n[1] = m2;   c_n[2] = v2;   end
      default: begin c_n[0] = v2;   c_n[1] = m2;   c_n[2] = down; end
    endcase
    if (vz2) begin
      c_n[0] = l2;
      c_n[1] = l2;
      c_n[2] = l2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd3 <= cmd2;
      for (int i = 0; i < 3; i++) c3[i] <= c_n[i];
    end
  end

  // Scale to a byte: floor(c * 255 / ONE), clamped; zero for RGB to HSL.
  always_comb begin
    logic [F+8:0] sc;
    for (int i = 0; i < 3; i++) begin
      sc = ({8'b0, c3[i]} << 8) - {8'b0, c3[i]};
      b_n[i] = (sc[F+8:F] > 9'd255) ? 8'd255 : sc[F+7:F];
      if (cmd3 != CMD_HSL2RGB) b_n[i] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= b_n[0];
      green <= b_n[1];
      blue  <= b_n[2];
    end
  end
endmodule

FILE: design/rgb_hsl_color_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL color converter
// Converts RGB to HSL or HSL to RGB, one item per clock, fully pipelined.
// ----------------------------------------------------------------------------
// Each result passes one front stage and then four stages of the divider
// lanes and reverse path running side by side.
// Throughput: one item per cycle; the pipeline holds as a whole while a
// result waits at the output.
// Reset clears the stage valid bits only; the data registers are not reset.
module rgb_hsl_color_converter #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  rhc_in_if.sink   pix_in,
  rhc_out_if.source pix_out
);
  import rhc_pkg::*;

  localparam int DEPTH = CORE_STAGES + 1;

  logic [DEPTH-1:0]       vld;
  logic                   en;
  fwd_t                   fwd;
  logic                   cmd_q, half_q;
  logic [FRAC_BITS-1:0]   hue_q;
  logic [FRAC_BITS:0]     sat_q, light_q;
  logic [2*FRAC_BITS+2:0] prod_q;

  // The whole pipeline advances unless a finished item is held at the output.
  assign en           = !vld[DEPTH-1] || pix_out.ready;
  assign pix_in.ready = en;
  assign pix_out.valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], pix_in.valid};
    end
  end

  rhc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .en       (en),
    .cmd      (pix_in.cmd),
    .red_in   (pix_in.red_in),
    .green_in (pix_in.green_in),
    .blue_in  (pix_in.blue_in),
    .hue_in   (pix_in.hue_in),
    .sat_in   (pix_in.sat_in),
    .light_in (pix_in.light_in),
    .fwd      (fwd),
    .cmd_q    (cmd_q),
    .hue_q    (hue_q),
    .sat_q    (sat_q),
    .light_q  (light_q),
    .prod_q   (prod_q),
    .half_q   (half_q)
  );

  rhc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .en    (en),
    .fwd   (fwd),
    .hue   (pix_out.hue_out),
    .sat   (pix_out.sat_out),
    .light (pix_out.light_out)
  );

  rhc_rev #(.FRAC_BITS(FRAC_BITS)) u_rev (
    .clk   (clk),
    .en    (en),
    .cmd   (cmd_q),
    .hue   (hue_q),
    .sat   (sat_q),
    .light (light_q),
    .prod  (prod_q),
    .half  (half_q),
    .red   (pix_out.red_out),
    .green (pix_out.green_out),
    .blue  (pix_out.blue_out)
  );
endmodule

FILE: design/rhc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB/HSL converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker #(
  parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [7:0]           red_out,
  input logic [7:0]           green_out,
  input logic [7:0]           blue_out,
  input logic [FRAC_BITS-1:0] hue_out,
  input logic [FRAC_BITS:0]   sat_out,
  input logic [FRAC_BITS:0]   light_out
);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // A held result keeps its valid and its fields.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(hue_out) && $stable(sat_out)
      && $stable(light_out))
    else $error("held result changed");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input is taken exactly when the output does not block.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // Only one direction's fields are nonzero, and lightness stays within one.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((red_out | green_out | blue_out) == 8'd0)
      || ((hue_out == '0) && (sat_out == '0) && (light_out == '0)))
      && (light_out <= ONE))
    else $error("result fields out of range");
endmodule

bind rgb_hsl_color_converter rhc_checker #(.FRAC_BITS(FRAC_BITS)) u_rhc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out),
  .green_out (pix_out.green_out),
  .blue_out  (pix_out.blue_out),
  .hue_out   (pix_out.hue_out),
  .sat_out   (pix_out.sat_out),
  .light_out (pix_out.light_out)
);
